// ===== sv/embedding_gather_scatter_add_assert.svh =====
// ----------------------------------------------------------------------------
// Embedding gather/scatter-add assertion macros
// Clocked assertion wrappers shared by the RTL; empty bodies under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef EMBEDDING_GATHER_SCATTER_ADD_ASSERT_SVH
`define EMBEDDING_GATHER_SCATTER_ADD_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define EGSA_ASSERT_IMP(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define EGSA_ASSERT_NXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("%m: assertion failed");

`else

`define EGSA_ASSERT_IMP(label, clk, rst_n, cond, conseq)

`define EGSA_ASSERT_NXT(label, clk, rst_n, cond, conseq)

`endif

`endif

// ===== sv/egsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Embedding gather/scatter-add package
// Shared types, mode codes and default sizes for the embedding table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package egsa_pkg;

    // default table geometry
    localparam int ROWS_DEF = 1024;
    localparam int COLS_DEF = 64;

    // configuration register indexes
    localparam int REG_ROWS_IN_USE = 0;

    // reset value of rows_in_use
    localparam logic [10:0] ROWS_IN_USE_RST = 11'd1024;

    // saturation limits of the Q10.13 gradient
    localparam logic signed [23:0] GRAD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] GRAD_MIN = 24'sh800000;

    // item modes
    typedef enum logic [2:0] {
        MODE_GATHER = 3'd0,
        MODE_ACCUM  = 3'd1,
        MODE_LOAD   = 3'd2,
        MODE_READ   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    // input word
    typedef struct packed {
        logic [2:0]          mode;
        logic signed [15:0]  token_index;
        logic [5:0]          column;
        logic signed [15:0]  value;
    } in_word_t;

    // result word
    typedef struct packed {
        logic signed [23:0]  result_value;
        logic                in_range;
        logic                saturated;
    } out_word_t;

    // request from the front end into the gradient unit
    typedef struct packed {
        logic                take;
        logic                accum;
        logic                clear;
        logic signed [15:0]  value;
    } grad_req_t;

    // status back from the gradient unit
    typedef struct packed {
        logic                busy;
        logic signed [23:0]  old_value;
        logic                sat;
    } grad_rsp_t;

endpackage

// ===== sv/egsa_wt_store.sv =====
// ----------------------------------------------------------------------------
// Embedding weight store
// Single-port synchronous weight memory; load writes, every item reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module egsa_wt_store #(
    parameter int ROWS = egsa_pkg::ROWS_DEF,
    parameter int COLS = egsa_pkg::COLS_DEF,
    localparam int DEPTH  = ROWS * COLS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                take,
    input  logic                we,
    input  logic [ADDR_W-1:0]   addr,
    input  logic [15:0]         wdata,
    output logic [15:0]         rdata
);

    logic [15:0] wt_mem [DEPTH];
    logic [15:0] rd_data_reg;

    // one access per accepted word; a load lands before any later gather reads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (we)
            begin
                wt_mem[addr] <= wdata;
            end
            rd_data_reg <= wt_mem[addr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ===== sv/egsa_grad_unit.sv =====
// ----------------------------------------------------------------------------
// Embedding gradient unit
// Gradient memory with read-modify-write accumulate, forwarding and a
// one-entry-per-cycle clearing sweep after reset and on a clear word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "embedding_gather_scatter_add_assert.svh"

module egsa_grad_unit #(
    parameter int ROWS = egsa_pkg::ROWS_DEF,
    parameter int COLS = egsa_pkg::COLS_DEF,
    localparam int DEPTH  = ROWS * COLS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  egsa_pkg::grad_req_t req,
    input  logic [ADDR_W-1:0]   addr,
    output egsa_pkg::grad_rsp_t rsp
);

    logic signed [23:0] grad_mem [DEPTH];

    // memory-side data
    logic signed [23:0] rd_data_reg;
    logic signed [23:0] fwd_data_reg;
    logic               fwd_hit_reg;

    // stage holding the word between read and write-back
    logic               acc_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic signed [15:0] value_reg;

    // clearing sweep
    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic               clr_last;

    logic signed [23:0] old_value;
    logic signed [24:0] sum_wide;
    logic signed [23:0] sum_sat;
    logic               sat;
    logic               fwd_hit;

    // old entry value: forward the write-back that shares the read edge
    assign old_value = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    // Q2.13 and Q10.13 share the fraction, so add after sign extension
    assign sum_wide = 25'(old_value) + 25'(value_reg);

    always_comb
    begin
        sat     = 1'b0;
        sum_sat = sum_wide[23:0];
        if (sum_wide > 25'(egsa_pkg::GRAD_MAX))
        begin
            sat     = 1'b1;
            sum_sat = egsa_pkg::GRAD_MAX;
        end
        else if (sum_wide < 25'(egsa_pkg::GRAD_MIN))
        begin
            sat     = 1'b1;
            sum_sat = egsa_pkg::GRAD_MIN;
        end
    end

    assign fwd_hit  = req.take && acc_reg && (addr == addr_reg);
    assign clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    // memory: sweep writes zero, otherwise accumulate writes back
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            grad_mem[clr_cnt_reg] <= '0;
        end
        else if (acc_reg)
        begin
            grad_mem[addr_reg] <= sum_sat;
        end
        if (req.take)
        begin
            rd_data_reg  <= grad_mem[addr];
            fwd_data_reg <= sum_sat;
        end
    end

    // payload of the write-back stage
    always_ff @(posedge clk)
    begin
        if (req.take)
        begin
            addr_reg  <= addr;
            value_reg <= req.value;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            acc_reg <= req.take && req.accum;
            if (req.take)
            begin
                fwd_hit_reg <= fwd_hit;
            end
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                if (clr_last)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            else if (req.take && req.clear)
            begin
                clearing_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
        end
    end

    assign rsp.busy      = clearing_reg;
    assign rsp.old_value = old_value;
    assign rsp.sat       = sat;

    // no word enters during the sweep
    `EGSA_ASSERT_IMP(a_no_take_busy, clk, rst_n, req.take, !clearing_reg)
    // a forward only follows an accumulate write-back
    `EGSA_ASSERT_IMP(a_fwd_after_acc, clk, rst_n, fwd_hit_reg && $past(req.take), $past(acc_reg))
    // the sweep stops right after the last entry
    `EGSA_ASSERT_NXT(a_sweep_end, clk, rst_n, clearing_reg && clr_last, !clearing_reg)

endmodule

// ===== sv/embedding_gather_scatter_add.sv =====
// ----------------------------------------------------------------------------
// Embedding gather/scatter-add engine
// Weight and gradient tables of ROWS x COLS entries with gather, accumulate,
// load, read and clear.
// ----------------------------------------------------------------------------
// Usage:
//   A word on item is accepted at a rising edge with start high and busy low.
//   One result word follows per accepted word: done is high for exactly one
//   cycle, raised via s1_valid_reg and done_reg, with result valid alongside.
//   Gather, accumulate, load and read take one word per cycle while busy
//   is low; the gradient read-modify-write forwards a write-back to a read
//   of the same entry. A clear word zeroes the gradient memory one entry
//   a cycle through its single write port: busy rises at the accepting
//   edge and stays high until the last entry is zeroed. After reset the
//   same sweep runs, and busy keeps the first word out until it ends.
//   Weights are undefined until loaded. rows_in_use sits at APB byte
//   address 0 and must be written while idle; the block does not enforce
//   it. The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "embedding_gather_scatter_add_assert.svh"

module embedding_gather_scatter_add #(
    parameter int ROWS = egsa_pkg::ROWS_DEF,
    parameter int COLS = egsa_pkg::COLS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // command
    input  logic                 start,
    output logic                 busy,
    input  egsa_pkg::in_word_t   item,
    output logic                 done,
    output egsa_pkg::out_word_t  result
);

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [16:0] ROW_CAP = 17'(ROWS);
    localparam logic [10:0] COL_CAP = 11'(COLS);

    logic [10:0]          rows_reg;

    logic                 accept;
    logic [16:0]          rows_ext;
    logic [16:0]          limit;
    logic                 row_ok;
    logic                 col_ok;
    logic                 access;
    logic [31:0]          lin_addr;
    logic [ADDR_W-1:0]    addr;
    egsa_pkg::mode_t      in_mode;

    // stage registers
    logic                 s1_valid_reg;
    logic [2:0]           s1_mode_reg;
    logic                 s1_range_reg;
    logic                 s1_access_reg;

    logic                 done_reg;
    egsa_pkg::out_word_t  out_reg;
    egsa_pkg::out_word_t  out_next;

    egsa_pkg::grad_req_t  grad_req;
    egsa_pkg::grad_rsp_t  grad_rsp;
    logic [15:0]          wt_rdata;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == 2'(egsa_pkg::REG_ROWS_IN_USE * 4)) ? {21'b0, rows_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= egsa_pkg::ROWS_IN_USE_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            rows_reg <= pwdata[10:0];
        end
    end

    // decode: row and column checks, linear address
    assign accept   = start && !busy;
    assign in_mode  = egsa_pkg::mode_t'(item.mode);
    assign rows_ext = {6'b0, rows_reg};
    assign limit    = (rows_ext > ROW_CAP) ? ROW_CAP : rows_ext;
    assign row_ok   = !item.token_index[15] && ({2'b0, item.token_index[14:0]} < limit);
    assign col_ok   = ({5'b0, item.column} < COL_CAP);
    assign access   = row_ok && col_ok;
    assign lin_addr = 32'(item.token_index[14:0]) * 32'(COLS) + 32'(item.column);
    assign addr     = access ? lin_addr[ADDR_W-1:0] : '0;

    // gradient request
    assign grad_req.take  = accept;
    assign grad_req.accum = access && (in_mode == egsa_pkg::MODE_ACCUM);
    assign grad_req.clear = (in_mode == egsa_pkg::MODE_CLEAR);
    assign grad_req.value = item.value;

    egsa_wt_store #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_wt_store (
        .clk   (clk),
        .take  (accept),
        .we    (access && (in_mode == egsa_pkg::MODE_LOAD)),
        .addr  (addr),
        .wdata (item.value),
        .rdata (wt_rdata)
    );

    egsa_grad_unit #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_grad_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (grad_req),
        .addr  (addr),
        .rsp   (grad_rsp)
    );

    assign busy = grad_rsp.busy;

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= item.mode;
            s1_range_reg  <= row_ok && (item.mode <= 3'(egsa_pkg::MODE_READ));
            s1_access_reg <= access;
        end
    end

    // result formatting
    always_comb
    begin
        out_next              = '0;
        out_next.in_range     = s1_range_reg;
        unique case (egsa_pkg::mode_t'(s1_mode_reg))
            egsa_pkg::MODE_GATHER:
            begin
                if (s1_access_reg)
                begin
                    out_next.result_value = {{8{wt_rdata[15]}}, wt_rdata};
                end
            end
            egsa_pkg::MODE_ACCUM:
            begin
                out_next.saturated = s1_access_reg && grad_rsp.sat;
            end
            egsa_pkg::MODE_READ:
            begin
                if (s1_access_reg)
                begin
                    out_next.result_value = grad_rsp.old_value;
                end
            end
            egsa_pkg::MODE_LOAD, egsa_pkg::MODE_CLEAR:
            begin
                out_next.in_range = s1_range_reg;
            end
            default:
            begin
                out_next.in_range = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

    // every result traces back to an accepted word carried through s1_valid_reg
    `EGSA_ASSERT_IMP(a_done_latency, clk, rst_n, done_reg, $past(accept, 2))
    // saturation is only reported for a row in range
    `EGSA_ASSERT_IMP(a_sat_in_range, clk, rst_n, done_reg && out_reg.saturated, out_reg.in_range)

endmodule

// ===== test/embedding_gather_scatter_add_tb.sv =====
// ----------------------------------------------------------------------------
// Embedding gather/scatter-add engine testbench
// Drives gather, accumulate, load, read and clear words through the command
// port and checks every result word against a mirror of both tables. The
// row limit is rewritten over APB between phases, including zero and values
// above the table size. Saturating runs push one gradient entry past each
// 24-bit limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module embedding_gather_scatter_add_tb
    import egsa_pkg::*;
();

    localparam int          DEPTH       = ROWS_DEF * COLS_DEF;
    localparam int          MODE_TOP    = (1 << $bits(mode_t)) - 1;
    localparam logic [1:0]  ADDR_ROWS   = 2'(REG_ROWS_IN_USE * 4);
    localparam int          DRAIN       = 4;
    localparam int          RUN_LEN     = 380;
    localparam int          CYCLE_LIMIT = 1_500_000;
    localparam int          MAX_SHOWN   = 40;
    localparam int          PHASES      = 6;

    // per-phase row limit (negative: pick one at random), word count, sender idle
    localparam int PLAN_ROWS [PHASES] = '{1024, 2047, 1, 0, -1, 1023};
    localparam int PLAN_LEN  [PHASES] = '{400, 300, 250, 150, 450, 275};
    localparam int PLAN_IDLE [PHASES] = '{13, 13, 57, 57, 0, 0};

    // ------------------------------------------------------------------------
    // Mirror of the weight and gradient tables plus the queue of due results
    // ------------------------------------------------------------------------
    class table_mirror;
        bit [15:0]        wt_mem   [DEPTH];
        bit               wt_known [DEPTH];
        bit signed [23:0] grad_mem [DEPTH];
        int               rows_cfg = int'(ROWS_IN_USE_RST);
        out_word_t        due_results [$];
        int               errors;
        int               n_words;
        int               n_checked;
        int               n_sat;
        int               n_clear;
        int               n_reject;

        function void set_rows(logic [10:0] v);
            rows_cfg = int'(v);
        endfunction

        // a limit above the table size acts as the table size
        function int limit();
            return (rows_cfg > ROWS_DEF) ? ROWS_DEF : rows_cfg;
        endfunction

        function bit row_valid(logic [15:0] tok);
            return !tok[15] && (int'(tok) < limit());
        endfunction

        // entry address and whether the word may touch it
        function bit locate(logic [15:0] tok, logic [5:0] col, output int unsigned a);
            a = int'(tok[14:0]) * COLS_DEF + int'(col);
            return row_valid(tok) && (int'(col) < COLS_DEF);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: mismatch: %s", $time, msg);
        endtask

        // work out the result of an accepted word and update the tables
        function void note_word(in_word_t w);
            out_word_t   e;
            int unsigned a;
            bit          hit;
            bit          row_ok;
            int          sum;
            e      = '0;
            hit    = locate(w.token_index, w.column, a);
            row_ok = row_valid(w.token_index);
            n_words++;
            if (w.mode <= MODE_READ)
            begin
                e.in_range = row_ok;
                if (!row_ok)
                    n_reject++;
            end
            case (w.mode)
                MODE_GATHER:
                    if (hit)
                        e.result_value = {{8{wt_mem[a][15]}}, wt_mem[a]};
                MODE_ACCUM:
                    if (hit)
                    begin
                        sum = int'(grad_mem[a]) + int'($signed(w.value));
                        if (sum > int'(GRAD_MAX))
                        begin
                            sum         = int'(GRAD_MAX);
                            e.saturated = 1'b1;
                        end
                        else if (sum < int'(GRAD_MIN))
                        begin
                            sum         = int'(GRAD_MIN);
                            e.saturated = 1'b1;
                        end
                        grad_mem[a] = 24'(sum);
                        if (e.saturated)
                            n_sat++;
                    end
                MODE_LOAD:
                    if (hit)
                    begin
                        wt_mem[a]   = w.value;
                        wt_known[a] = 1'b1;
                    end
                MODE_READ:
                    if (hit)
                        e.result_value = grad_mem[a];
                MODE_CLEAR:
                begin
                    foreach (grad_mem[i])
                        grad_mem[i] = '0;
                    n_clear++;
                end
                default: ;
            endcase
            due_results.push_back(e);
        endfunction

        // compare a result word with the oldest due one, field by field
        task check_word(out_word_t got);
            out_word_t e;
            if (due_results.size() == 0)
            begin
                report($sformatf("result word %h with nothing due", got));
                return;
            end
            e = due_results.pop_front();
            n_checked++;
            if (got.result_value !== e.result_value)
                report($sformatf("result_value %h, want %h", got.result_value, e.result_value));
            if (got.in_range !== e.in_range)
                report($sformatf("in_range %b, want %b", got.in_range, e.in_range));
            if (got.saturated !== e.saturated)
                report($sformatf("saturated %b, want %b", got.saturated, e.saturated));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, ports and block
    // ------------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start   = 1'b0;
    logic        busy;
    in_word_t    item    = '0;
    logic        done;
    out_word_t   result;

    table_mirror mirror = new();

    // generator state
    int unsigned loaded_addrs [$];
    logic [15:0] last_tok;
    logic [5:0]  last_col;
    bit          have_last;
    int          clears_left;
    int          cycle_count;

    always #1 clk = ~clk;

    embedding_gather_scatter_add #(
        .ROWS (ROWS_DEF),
        .COLS (COLS_DEF)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result)
    );

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_word(result);
    end

    // ------------------------------------------------------------------------
    // Drivers (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic issue_word(input in_word_t w, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.note_word(w);
        @(negedge clk);
    endtask

    // drop start and wait for every due word and any clear sweep
    task automatic settle();
        start <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
        @(negedge clk);
    endtask

    // APB write of the row limit, then read it back
    task automatic write_rows(input logic [10:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ROWS;
        pwdata  <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[10:0] !== v)
            mirror.report($sformatf("rows_in_use reads %h, want %h", prdata[10:0], v));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        mirror.set_rows(v);
    endtask

    // ------------------------------------------------------------------------
    // Word generators
    // ------------------------------------------------------------------------
    function automatic in_word_t word_of(input logic [2:0] m, input logic [15:0] tok,
                                         input logic [5:0] col, input logic [15:0] val);
        in_word_t w;
        w.mode        = m;
        w.token_index = tok;
        w.column      = col;
        w.value       = val;
        return w;
    endfunction

    // rows: mostly valid, plus negative, past the limit, at the boundary, anything
    function automatic logic [15:0] pick_token(input int lim);
        case ($urandom_range(9))
            0:       return 16'($urandom_range(32768, 65535));
            1:       return 16'($urandom_range(lim, 32767));
            2:       return 16'((lim == 0) ? 0 : lim - 1 + $urandom_range(1));
            3:       return 16'($urandom);
            default: return 16'((lim == 0) ? $urandom_range(32767) : $urandom_range(lim - 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned a;
        int          r;
        int          lim;
        lim           = mirror.limit();
        r             = $urandom_range(99);
        w.token_index = pick_token(lim);
        w.column      = 6'($urandom);
        w.value       = pick_value();
        // revisit the last entry to hit the forwarding path
        if (have_last && $urandom_range(3) == 0)
        begin
            w.token_index = last_tok;
            w.column      = last_col;
        end
        if (clears_left > 0 && $urandom_range(399) == 0)
        begin
            clears_left--;
            w.mode = MODE_CLEAR;
        end
        else if (r < 25)
        begin
            w.mode = MODE_GATHER;
            if (loaded_addrs.size() > 0 && $urandom_range(9) < 5)
            begin
                a             = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
                w.token_index = 16'(a / COLS_DEF);
                w.column      = 6'(a % COLS_DEF);
            end
            // never gather a weight that was not loaded
            if (mirror.locate(w.token_index, w.column, a) && !mirror.wt_known[a])
                w.token_index = 16'($urandom_range(32768, 65535));
        end
        else if (r < 60)
            w.mode = MODE_ACCUM;
        else if (r < 78)
        begin
            w.mode = MODE_LOAD;
            if (mirror.locate(w.token_index, w.column, a) && !mirror.wt_known[a])
                loaded_addrs.push_back(a);
        end
        else if (r < 94)
            w.mode = MODE_READ;
        else
            w.mode = 3'($urandom_range(int'(MODE_CLEAR) + 1, MODE_TOP));
        last_tok  = w.token_index;
        last_col  = w.column;
        have_last = 1'b1;
        return w;
    endfunction

    // drive one gradient entry past a limit, with reads and noise mixed in
    task automatic saturating_run(input bit downward, input int idle_pct);
        in_word_t    w;
        logic [15:0] tok;
        logic [5:0]  col;
        logic [15:0] push;
        int          r;
        tok = 16'($urandom_range(mirror.limit() - 1));
        col = 6'($urandom);
        for (int k = 0; k < RUN_LEN; k++)
        begin
            r    = $urandom_range(99);
            push = downward ? 16'(-$urandom_range(30000, 32768))
                            : 16'($urandom_range(30000, 32767));
            if (r < 85)
                w = word_of(MODE_ACCUM, tok, col, push);
            else if (r < 95)
                w = word_of(MODE_READ, tok, col, pick_value());
            else
                w = random_word();
            issue_word(w, idle_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int quota;
        int rows_val;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words at the reset row limit
        issue_word(word_of(MODE_LOAD,   16'd0,      6'd0,  16'h7FFF), 0);
        issue_word(word_of(MODE_GATHER, 16'd0,      6'd0,  16'h0000), 0);
        issue_word(word_of(MODE_LOAD,   16'd1023,   6'd63, 16'h8000), 0);
        issue_word(word_of(MODE_GATHER, 16'd1023,   6'd63, 16'hFFFF), 0);
        issue_word(word_of(MODE_GATHER, 16'd1024,   6'd0,  16'h0000), 0);
        issue_word(word_of(MODE_GATHER, 16'hFFFF,   6'd0,  16'h0000), 0);
        issue_word(word_of(MODE_GATHER, 16'h8000,   6'd63, 16'h0000), 0);
        issue_word(word_of(MODE_GATHER, 16'h7FFF,   6'd5,  16'h0000), 0);
        issue_word(word_of(MODE_ACCUM,  16'd5,      6'd5,  16'h7FFF), 0);
        issue_word(word_of(MODE_ACCUM,  16'd5,      6'd5,  16'h7FFF), 0);
        issue_word(word_of(MODE_READ,   16'd5,      6'd5,  16'h0000), 0);
        issue_word(word_of(MODE_ACCUM,  16'd5,      6'd5,  16'h8000), 0);
        issue_word(word_of(MODE_ACCUM,  16'd1024,   6'd5,  16'h0064), 0);
        issue_word(word_of(MODE_LOAD,   16'hFFFB,   6'd1,  16'h1234), 0);
        issue_word(word_of(MODE_READ,   16'd1023,   6'd63, 16'h0000), 0);
        issue_word(word_of(MODE_ACCUM,  16'd1023,   6'd63, 16'h8000), 0);
        issue_word(word_of(MODE_READ,   16'd1023,   6'd63, 16'h0000), 0);
        for (int m = int'(MODE_CLEAR) + 1; m <= MODE_TOP; m++)
            issue_word(word_of(3'(m), 16'd0, 6'd0, 16'($urandom)), 0);
        issue_word(word_of(MODE_CLEAR,  16'hFFFF,   6'd63, 16'hFFFF), 0);
        issue_word(word_of(MODE_READ,   16'd5,      6'd5,  16'h0000), 0);
        issue_word(word_of(MODE_ACCUM,  16'd0,      6'd0,  16'hFFFF), 0);
        issue_word(word_of(MODE_READ,   16'd0,      6'd0,  16'h0000), 0);
        issue_word(word_of(MODE_LOAD,   16'd0,      6'd0,  16'h5AA5), 0);
        issue_word(word_of(MODE_GATHER, 16'd0,      6'd0,  16'h0000), 0);
        loaded_addrs.push_back(0);
        loaded_addrs.push_back(1023 * COLS_DEF + 63);
        clears_left = 3;

        // random phases, each under its own row limit and sender idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            rows_val = (PLAN_ROWS[ph] < 0) ? $urandom_range(2, 1023) : PLAN_ROWS[ph];
            write_rows(11'(rows_val));
            quota = PLAN_LEN[ph];
            if (ph == 0 || ph == 4)
            begin
                saturating_run(ph == 4, PLAN_IDLE[ph]);
                quota -= RUN_LEN;
            end
            for (int k = 0; k < quota; k++)
                issue_word(random_word(), PLAN_IDLE[ph]);
        end
        settle();

        $display("Run covered %0d words, %0d result words checked, %0d clears.",
                 mirror.n_words, mirror.n_checked, mirror.n_clear);
        $display("Saw %0d saturating adds and %0d rejected rows over %0d row limits.",
                 mirror.n_sat, mirror.n_reject, PHASES);
        if (mirror.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // timeout
    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Timeout after %0d cycles.", CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
